### rtl/core/aet_pkg.sv
package aet_pkg;

    // Token kinds as they leave the block.
    typedef enum logic [3:0] {
        KIND_NUMBER  = 4'd0,
        KIND_LPAREN  = 4'd1,
        KIND_RPAREN  = 4'd2,
        KIND_PLUS    = 4'd3,
        KIND_MINUS   = 4'd4,
        KIND_STAR    = 4'd5,
        KIND_SLASH   = 4'd6,
        KIND_SEMI    = 4'd7,
        KIND_EOL     = 4'd8,
        KIND_EOF     = 4'd9,
        KIND_UNKNOWN = 4'd10
    } t_kind;

    // Error codes attached to a token.
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_POINT    = 2'd1,
        ERR_BYTE     = 2'd2,
        ERR_OVERFLOW = 2'd3
    } t_err;

    // Byte classes decided by the front end.
    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_POINT,
        CLS_SPACE,
        CLS_EOF,
        CLS_NEWLINE,
        CLS_PUNCT,
        CLS_OTHER
    } t_cls;

    // Source characters the classifier looks for.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    localparam logic [15:0] MAX16    = 16'hFFFF;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
    localparam logic [4:0]  FRAC_MAX = 5'd31;

    localparam int AET_QUEUE_DEPTH = 4;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        t_cls       cls;
        t_kind      kind;
        logic [3:0] digit;
    } t_item;

    // One result token.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] mantissa;
        logic [4:0]  frac;
        logic [15:0] line;
        logic [15:0] column;
        t_err        err;
        logic        last;
    } t_tok;

endpackage

### rtl/core/aet_front.sv
module aet_front (
    input  logic [7:0]    i_char_byte,
    output aet_pkg::t_item o_item
);
    import aet_pkg::*;

    // Decode the byte into a class, a token kind and a digit value.
    always_comb begin
        o_item.digit = 4'(i_char_byte - CH_ZERO);
        o_item.kind  = KIND_UNKNOWN;
        o_item.cls   = CLS_OTHER;
        unique case (i_char_byte) inside
            [CH_ZERO:CH_NINE]:        o_item.cls = CLS_DIGIT;
            CH_POINT:                 o_item.cls = CLS_POINT;
            CH_SPACE, CH_TAB, CH_CR:  o_item.cls = CLS_SPACE;
            CH_NUL:                   o_item.cls = CLS_EOF;
            CH_NEWLINE: begin
                o_item.cls  = CLS_NEWLINE;
                o_item.kind = KIND_EOL;
            end
            CH_LPAREN: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_LPAREN;
            end
            CH_RPAREN: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_RPAREN;
            end
            CH_PLUS: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_PLUS;
            end
            CH_MINUS: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_MINUS;
            end
            CH_STAR: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_STAR;
            end
            CH_SLASH: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_SLASH;
            end
            CH_SEMI: begin
                o_item.cls  = CLS_PUNCT;
                o_item.kind = KIND_SEMI;
            end
            default: o_item.cls = CLS_OTHER;
        endcase
    end

endmodule

### rtl/core/aet_queue.sv
module aet_queue #(
    parameter int DEPTH = aet_pkg::AET_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  aet_pkg::t_item i_wr_item,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output aet_pkg::t_item o_rd_item
);
    import aet_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_head];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Storage write at the tail.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= i_wr_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_tail <= (r_tail == LAST_PTR) ? '0 : r_tail + PW'(1);
            end
            if (pop) begin
                r_head <= (r_head == LAST_PTR) ? '0 : r_head + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/core/aet_back.sv
module aet_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  aet_pkg::t_item i_item,
    output logic           o_tok_valid,
    input  logic           i_tok_ready,
    output aet_pkg::t_tok  o_tok
);
    import aet_pkg::*;

    // Scanner state.
    logic        r_in_number, n_in_number;
    logic        r_seen_point, n_seen_point;
    logic [31:0] r_mant, n_mant;
    logic [4:0]  r_frac, n_frac;
    logic        r_ovf, n_ovf;
    logic [15:0] r_start_line, n_start_line;
    logic [15:0] r_start_col, n_start_col;
    logic [15:0] r_cur_line, n_cur_line;
    logic [15:0] r_cur_col, n_cur_col;

    // Output slot and the pending second token.
    t_tok r_out;
    logic r_out_valid;
    t_tok r_pend;
    logic r_pend_valid;

    logic        slot_free;
    logic        take;
    logic [35:0] acc_next;
    logic        fits;
    logic [15:0] cons_line;
    logic [15:0] cons_col;
    logic        num_emit;
    t_err        num_err;
    logic        fresh;
    logic        fresh_have;
    t_tok        num_tok;
    t_tok        fresh_tok;
    t_tok        tok0;
    t_tok        tok1;
    logic        have0;
    logic        have1;

    assign slot_free    = !r_out_valid || i_tok_ready;
    assign o_item_ready = slot_free && !r_pend_valid;
    assign take         = i_item_valid && o_item_ready;
    assign o_tok_valid  = r_out_valid;
    assign o_tok        = r_out;

    // Mantissa times ten plus the new digit; it fits when no bit lands above bit 31.
    assign acc_next = ({4'd0, r_mant} << 3) + ({4'd0, r_mant} << 1) + {32'd0, i_item.digit};
    assign fits     = (acc_next[35:32] == 4'd0);

    // Position after consuming this byte.
    always_comb begin
        if (i_item.cls == CLS_NEWLINE) begin
            cons_line = (r_cur_line == MAX16) ? r_cur_line : r_cur_line + 16'd1;
            cons_col  = 16'd1;
        end else begin
            cons_line = r_cur_line;
            cons_col  = (r_cur_col == MAX16) ? r_cur_col : r_cur_col + 16'd1;
        end
    end

    // Scanner step: next state and up to two tokens.
    always_comb begin
        n_in_number  = r_in_number;
        n_seen_point = r_seen_point;
        n_mant       = r_mant;
        n_frac       = r_frac;
        n_ovf        = r_ovf;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        num_emit     = 1'b0;
        num_err      = ERR_NONE;
        fresh        = 1'b0;
        fresh_have   = 1'b0;

        fresh_tok.kind     = i_item.kind;
        fresh_tok.mantissa = '0;
        fresh_tok.frac     = '0;
        fresh_tok.line     = r_cur_line;
        fresh_tok.column   = r_cur_col;
        fresh_tok.err      = (i_item.kind == KIND_UNKNOWN) ? ERR_BYTE : ERR_NONE;
        fresh_tok.last     = 1'b1;

        if (r_in_number) begin
            if (i_item.cls == CLS_DIGIT) begin
                if (r_seen_point) begin
                    if (fits && r_frac != FRAC_MAX) begin
                        n_mant = acc_next[31:0];
                        n_frac = r_frac + 5'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (fits) begin
                    n_mant = acc_next[31:0];
                end else begin
                    n_mant = MAX32;
                    n_ovf  = 1'b1;
                end
                n_cur_line = cons_line;
                n_cur_col  = cons_col;
            end else if (i_item.cls == CLS_POINT && !r_seen_point) begin
                n_seen_point = 1'b1;
                n_cur_line   = cons_line;
                n_cur_col    = cons_col;
            end else begin
                // The number ends here; a second point also becomes an unknown token.
                num_emit     = 1'b1;
                n_in_number  = 1'b0;
                n_seen_point = 1'b0;
                n_mant       = '0;
                n_frac       = '0;
                n_ovf        = 1'b0;
                if (i_item.cls == CLS_POINT) begin
                    num_err       = ERR_POINT;
                    fresh_have    = 1'b1;
                    fresh_tok.kind = KIND_UNKNOWN;
                    fresh_tok.err  = ERR_BYTE;
                    n_cur_line    = cons_line;
                    n_cur_col     = cons_col;
                end else begin
                    num_err = r_ovf ? ERR_OVERFLOW : ERR_NONE;
                    fresh   = 1'b1;
                end
            end
        end else begin
            fresh = 1'b1;
        end

        // A byte handled with no number in progress, or after it has ended the number.
        if (fresh) begin
            unique case (i_item.cls)
                CLS_SPACE: begin
                    n_cur_line = cons_line;
                    n_cur_col  = cons_col;
                end
                CLS_DIGIT: begin
                    n_in_number  = 1'b1;
                    n_seen_point = 1'b0;
                    n_mant       = {28'd0, i_item.digit};
                    n_frac       = '0;
                    n_ovf        = 1'b0;
                    n_start_line = r_cur_line;
                    n_start_col  = r_cur_col;
                    n_cur_line   = cons_line;
                    n_cur_col    = cons_col;
                end
                CLS_EOF: begin
                    fresh_have     = 1'b1;
                    fresh_tok.kind = KIND_EOF;
                    fresh_tok.err  = ERR_NONE;
                    n_cur_line     = 16'd1;
                    n_cur_col      = 16'd0;
                end
                default: begin
                    fresh_have = 1'b1;
                    n_cur_line = cons_line;
                    n_cur_col  = cons_col;
                end
            endcase
        end

        num_tok.kind     = KIND_NUMBER;
        num_tok.mantissa = r_mant;
        num_tok.frac     = r_frac;
        num_tok.line     = r_start_line;
        num_tok.column   = r_start_col;
        num_tok.err      = num_err;
        num_tok.last     = !fresh_have;

        have0 = num_emit || fresh_have;
        have1 = num_emit && fresh_have;
        tok0  = num_emit ? num_tok : fresh_tok;
        tok1  = fresh_tok;
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number  <= 1'b0;
            r_seen_point <= 1'b0;
            r_mant       <= '0;
            r_frac       <= '0;
            r_ovf        <= 1'b0;
            r_start_line <= 16'd1;
            r_start_col  <= 16'd0;
            r_cur_line   <= 16'd1;
            r_cur_col    <= 16'd0;
        end else if (take) begin
            r_in_number  <= n_in_number;
            r_seen_point <= n_seen_point;
            r_mant       <= n_mant;
            r_frac       <= n_frac;
            r_ovf        <= n_ovf;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
        end
    end

    // Output valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (take) begin
            r_out_valid  <= have0 || (r_out_valid && !i_tok_ready);
            r_pend_valid <= have1;
        end else if (r_pend_valid && slot_free) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= r_out_valid && !i_tok_ready;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (have0) begin
                r_out <= tok0;
            end
            if (have1) begin
                r_pend <= tok1;
            end
        end else if (r_pend_valid && slot_free) begin
            r_out <= r_pend;
        end
    end

`ifndef SYNTHESIS
    // A second token only waits behind a first one.
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending token without a token in the output slot");

    // The token ahead of a pending one is never the last of its byte.
    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (!r_out.last && r_pend.last))
        else $error("last flag out of order across a token pair");

    // A decimal point is only recorded inside a number.
    a_point_in_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_point |-> r_in_number)
        else $error("decimal point seen outside a number");

    // Fractional digits exist only after a point.
    a_frac_after_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frac != 5'd0) |-> r_seen_point)
        else $error("fractional digits without a decimal point");
`endif

endmodule

### rtl/core/arithmetic_expression_tokenizer_core.sv
// Arithmetic expression tokenizer. One source byte enters per beat on the input channel
// and each byte causes zero, one or two tokens on the output channel, the last of them
// flagged by o_last_of_run. A front decoder classifies each byte into a short queue; the
// scanner behind it updates the number and position state and fills a one-token output
// register plus a one-token holding slot. A byte is taken every cycle while the output is
// drained and the queue has room; a byte that ends a number and also yields a token of
// its own holds the scanner until its second token leaves the holding slot, since only
// one token leaves per cycle, and the queue absorbs that wait. A byte is registered in the
// queue, then its first token in the output register. No clearing pass runs after reset.
module arithmetic_expression_tokenizer_core #(
    parameter int QUEUE_DEPTH = aet_pkg::AET_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_number_mantissa,
    output logic [4:0]  o_fraction_digits,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);
    import aet_pkg::*;

    t_item front_item;
    t_item q_item;
    logic  q_valid;
    logic  q_ready;
    t_tok  tok;

    aet_front u_front (
        .i_char_byte (i_char_byte),
        .o_item      (front_item)
    );

    aet_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_in_valid),
        .o_wr_ready (o_in_ready),
        .i_wr_item  (front_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    aet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .o_tok_valid  (o_out_valid),
        .i_tok_ready  (i_out_ready),
        .o_tok        (tok)
    );

    assign o_token_kind      = tok.kind;
    assign o_number_mantissa = tok.mantissa;
    assign o_fraction_digits = tok.frac;
    assign o_token_line      = tok.line;
    assign o_token_column    = tok.column;
    assign o_error_code      = tok.err;
    assign o_last_of_run     = tok.last;

endmodule

### tb/tb_top.sv
module tb_top;

    import aet_pkg::*;

    // Cycles to wait after the last expected token, and the watchdog limit.
    localparam int TAIL_CYCLES = 12;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_token_kind;
    logic [31:0] o_number_mantissa;
    logic [4:0]  o_fraction_digits;
    logic [15:0] o_token_line;
    logic [15:0] o_token_column;
    logic [1:0]  o_error_code;
    logic        o_last_of_run;

    // Idle percentages of the two channels for the current phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int error_count = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    // Tokens predicted but not yet seen on the output, oldest first.
    t_tok tokens_due[$];

    // Scanner state of the predictor.
    logic        num_open = 1'b0;
    logic        point_open = 1'b0;
    logic [31:0] acc_mant = '0;
    logic [4:0]  acc_frac = '0;
    logic        ovf_open = 1'b0;
    logic [15:0] num_line = 16'd1;
    logic [15:0] num_col = 16'd0;
    logic [15:0] line_pos = 16'd1;
    logic [15:0] col_pos = 16'd0;

    arithmetic_expression_tokenizer_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_byte       (i_char_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_token_kind      (o_token_kind),
        .o_number_mantissa (o_number_mantissa),
        .o_fraction_digits (o_fraction_digits),
        .o_token_line      (o_token_line),
        .o_token_column    (o_token_column),
        .o_error_code      (o_error_code),
        .o_last_of_run     (o_last_of_run)
    );

    // Free-running clock, period 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random according to the phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_tok make_token(t_kind kind, logic [31:0] mant, logic [4:0] frac,
                                        logic [15:0] line, logic [15:0] col, t_err err);
        t_tok t;
        t.kind = kind;
        t.mantissa = mant;
        t.frac = frac;
        t.line = line;
        t.column = col;
        t.err = err;
        t.last = 1'b0;
        return t;
    endfunction

    // Every consumed byte moves the position; a newline starts a new line at column 1.
    function automatic void advance_position(logic [7:0] c);
        if (c == CH_NEWLINE) begin
            if (line_pos < MAX16) line_pos = line_pos + 16'd1;
            col_pos = 16'd1;
        end else if (col_pos < MAX16) begin
            col_pos = col_pos + 16'd1;
        end
    endfunction

    // Closes the number in progress and returns its token.
    function automatic t_tok close_number(t_err err);
        t_tok t;
        t = make_token(KIND_NUMBER, acc_mant, acc_frac, num_line, num_col, err);
        num_open = 1'b0;
        point_open = 1'b0;
        acc_mant = '0;
        acc_frac = '0;
        ovf_open = 1'b0;
        return t;
    endfunction

    // Works out the tokens caused by one accepted byte and queues them.
    function automatic void scan_byte(logic [7:0] c);
        t_tok        made[$];
        logic        is_digit;
        logic        fits;
        logic        done;
        logic [31:0] d;
        t_kind       kind;
        t_err        err;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d = {28'd0, c[3:0]};
        done = 1'b0;

        // A number in progress either takes the byte or is ended by it.
        if (num_open) begin
            if (is_digit) begin
                fits = (acc_mant <= (MAX32 - d) / 32'd10);
                if (point_open) begin
                    if (fits && acc_frac < FRAC_MAX) begin
                        acc_mant = acc_mant * 32'd10 + d;
                        acc_frac = acc_frac + 5'd1;
                    end else begin
                        ovf_open = 1'b1;
                    end
                end else if (fits) begin
                    acc_mant = acc_mant * 32'd10 + d;
                end else begin
                    acc_mant = MAX32;
                    ovf_open = 1'b1;
                end
                advance_position(c);
                done = 1'b1;
            end else if (c == CH_POINT && !point_open) begin
                point_open = 1'b1;
                advance_position(c);
                done = 1'b1;
            end else if (c == CH_POINT) begin
                made.push_back(close_number(ERR_POINT));
                made.push_back(make_token(KIND_UNKNOWN, '0, '0, line_pos, col_pos, ERR_BYTE));
                advance_position(c);
                done = 1'b1;
            end else begin
                made.push_back(close_number(ovf_open ? ERR_OVERFLOW : ERR_NONE));
            end
        end

        // The byte handled as if no number were in progress.
        if (!done) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
                advance_position(c);
            end else if (is_digit) begin
                num_open = 1'b1;
                point_open = 1'b0;
                acc_mant = d;
                acc_frac = '0;
                ovf_open = 1'b0;
                num_line = line_pos;
                num_col = col_pos;
                advance_position(c);
            end else if (c == CH_NUL) begin
                made.push_back(make_token(KIND_EOF, '0, '0, line_pos, col_pos, ERR_NONE));
                line_pos = 16'd1;
                col_pos = 16'd0;
            end else begin
                err = ERR_NONE;
                case (c)
                    CH_LPAREN:  kind = KIND_LPAREN;
                    CH_RPAREN:  kind = KIND_RPAREN;
                    CH_PLUS:    kind = KIND_PLUS;
                    CH_MINUS:   kind = KIND_MINUS;
                    CH_STAR:    kind = KIND_STAR;
                    CH_SLASH:   kind = KIND_SLASH;
                    CH_SEMI:    kind = KIND_SEMI;
                    CH_NEWLINE: kind = KIND_EOL;
                    default: begin
                        kind = KIND_UNKNOWN;
                        err = ERR_BYTE;
                    end
                endcase
                made.push_back(make_token(kind, '0, '0, line_pos, col_pos, err));
                advance_position(c);
            end
        end

        if (made.size() > 0) made[made.size() - 1].last = 1'b1;
        foreach (made[i]) tokens_due.push_back(made[i]);
    endfunction

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Predicts on every input beat, checks every output beat, and runs the watchdog.
    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) scan_byte(i_char_byte);
            if (o_out_valid && i_out_ready) begin
                if (tokens_due.size() == 0) begin
                    error_count++;
                    $display("%0t: token with nothing expected, expected none, actual kind %0d",
                             $time, o_token_kind);
                end else begin
                    want = tokens_due.pop_front();
                    report_field("token_kind", 32'(want.kind), 32'(o_token_kind));
                    report_field("number_mantissa", want.mantissa, o_number_mantissa);
                    report_field("fraction_digits", 32'(want.frac), 32'(o_fraction_digits));
                    report_field("token_line", 32'(want.line), 32'(o_token_line));
                    report_field("token_column", 32'(want.column), 32'(o_token_column));
                    report_field("error_code", 32'(want.err), 32'(o_error_code));
                    report_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: watchdog expired with %0d tokens outstanding",
                             $time, tokens_due.size());
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Sends one byte, idling first at random; valid stays high until the beat.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Holds the input off until every predicted token has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Every punctuation byte, the skipped bytes, newline, unknown bytes and end of input.
    task automatic test_single_bytes();
        set_phase(0, 0);
        send_text("()+-*/;");
        send_text(" \t\r\n");
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_text(".;");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
        wait_drained();
    endtask

    // Numbers ended by an operator, a second point, a newline and end of input.
    task automatic test_number_ends();
        set_phase(8, 8);
        send_text("12.5+0.0 ");
        send_text("3.4.9");
        send_text("\n7\n");
        send_byte(CH_NUL);
        send_text("8");
        send_byte(CH_NUL);
        send_text("(6.)");
        wait_drained();
    endtask

    // Mantissa at its limit, saturation, fractional overflow and the digit count cap.
    task automatic test_number_overflow();
        set_phase(8, 8);
        send_text("4294967295;4294967296;99999999999 ");
        send_text("1.000000000000;");
        send_text("0.");
        repeat (34) send_byte(CH_ZERO);
        send_text(" 4294967296.5.");
        send_byte(CH_NUL);
        wait_drained();
    endtask

    // Column and line tracking over long runs of blanks and newlines.
    task automatic test_position_tracking();
        set_phase(0, 0);
        repeat (70) send_byte(CH_SPACE);
        send_text("+12 .\n");
        repeat (25) send_byte(CH_NEWLINE);
        send_text("5*5");
        send_byte(CH_NUL);
        send_text("+");
        wait_drained();
    endtask

    task automatic send_random_number();
        int n_int;
        int n_frac;
        n_int = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
        repeat (n_int) send_byte(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(99) < 40) begin
            send_byte(CH_POINT);
            n_frac = ($urandom_range(19) == 0) ? $urandom_range(10, 34) : $urandom_range(0, 4);
            repeat (n_frac) send_byte(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(19) == 0) send_byte(CH_POINT);
        end
    endtask

    // Mostly expression-shaped text with random content, with some raw noise bytes.
    task automatic test_random_stream(input int n_bytes, input int send_pct, input int recv_pct);
        string ops;
        string blanks;
        int    stop_at;
        int    pick;
        ops = "()+-*/;";
        blanks = " \t\r";
        stop_at = bytes_sent + n_bytes;
        set_phase(send_pct, recv_pct);
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) send_random_number();
            else if (pick < 60) send_byte(ops[$urandom_range(ops.len() - 1)]);
            else if (pick < 75) send_byte(blanks[$urandom_range(blanks.len() - 1)]);
            else if (pick < 83) send_byte(CH_NEWLINE);
            else if (pick < 85) send_byte(CH_NUL);
            else send_byte(8'($urandom_range(255)));
            // Now and then the sender waits for the output to empty.
            if ($urandom_range(79) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_number_ends();
        test_number_overflow();
        test_position_tracking();
        test_random_stream(275, 0, 0);
        test_random_stream(275, 76, 0);
        test_random_stream(275, 0, 76);
        test_random_stream(275, 8, 8);

        wait_drained();
        if (tokens_due.size() != 0) begin
            error_count++;
            $display("%0t: %0d tokens never arrived", $time, tokens_due.size());
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### arithmetic_expression_tokenizer_core.f
rtl/core/aet_pkg.sv
rtl/core/aet_front.sv
rtl/core/aet_queue.sv
rtl/core/aet_back.sv
rtl/core/arithmetic_expression_tokenizer_core.sv
tb/tb_top.sv
